// ===== rtl/lpt_pkg.sv =====
// Shared constants and types of the linear pose trajectory generator.
package lpt_pkg;

    // Axis counts: the first LINEAR_AXES axes are linear, the rest angular.
    localparam int AXES        = 6;
    localparam int LINEAR_AXES = 3;

    // Pi in Q16.16 and the interval used when the computed one is zero (1 ms in Q16.16).
    localparam logic [31:0] PI_Q16       = 32'd205887;
    localparam logic [30:0] MIN_INTERVAL = 31'd66;

    // Quotient bits produced by the shared divider, one per cycle.
    localparam int DIV_STEPS = 49;

    // Item kinds; the last code is unused and ignored.
    localparam logic [1:0] KIND_LOAD   = 2'd0;
    localparam logic [1:0] KIND_TARGET = 2'd1;
    localparam logic [1:0] KIND_TICK   = 2'd2;
    localparam logic [1:0] KIND_NONE   = 2'd3;

    // Configuration register indexes.
    localparam logic REG_SPEED     = 1'b0;
    localparam logic REG_TIME_STEP = 1'b1;

    typedef logic signed [31:0] coord_t;

endpackage

// ===== rtl/linear_pose_trajectory_generator.sv =====
// Top level of the six-axis linear pose trajectory generator.
//
// Channel   Direction  Handshake            Payload
// in        sink       in_valid / in_stall  kind, lin_a..lin_c, ang_a..ang_c
// out       source     out_valid/out_stall  pt_lin_a..pt_ang_c, final_point
// cfg       sink       cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A load item only sets the pose; a tick of a running move does six multiplies
// and six sums through one shared multiplier, and a target does ten divisions through
// the shared restoring divider, which yields one quotient bit per cycle.
// Reset is asynchronous and active low; it clears the pose and the mode and sets the registers to their defaults.
// A new item is taken while a point still waits on out; a stalled out only holds
// the block at its final push step.
module linear_pose_trajectory_generator
    import lpt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         kind,
    input  logic signed [31:0] lin_a,
    input  logic signed [31:0] lin_b,
    input  logic signed [31:0] lin_c,
    input  logic signed [31:0] ang_a,
    input  logic signed [31:0] ang_b,
    input  logic signed [31:0] ang_c,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] pt_lin_a,
    output logic signed [31:0] pt_lin_b,
    output logic signed [31:0] pt_lin_c,
    output logic signed [31:0] pt_ang_a,
    output logic signed [31:0] pt_ang_b,
    output logic signed [31:0] pt_ang_c,
    output logic               final_point,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [30:0]        cfg_data
);

    typedef enum logic [8:0] {
        ST_IDLE        = 9'b000000001,
        ST_MAG         = 9'b000000010,
        ST_ANG_DIV     = 9'b000000100,
        ST_IV_DIV      = 9'b000001000,
        ST_SLOPE_START = 9'b000010000,
        ST_SLOPE_DIV   = 9'b000100000,
        ST_MUL         = 9'b001000000,
        ST_ACC         = 9'b010000000,
        ST_PUSH        = 9'b100000000
    } state_t;

    state_t       state_reg;
    logic [2:0]   idx_reg;
    logic         moving_reg;
    logic         out_valid_reg;
    logic [30:0]  speed_reg;
    logic [30:0]  tstep_reg;
    coord_t       cur_reg [AXES];

    logic signed [32:0] diff_reg  [AXES];
    coord_t             start_reg [AXES];
    coord_t             slope_reg [AXES];
    coord_t             work_reg  [AXES];
    coord_t             pt_reg    [AXES];
    logic [32:0]  max_reg;
    logic [30:0]  interval_reg;
    logic [30:0]  elapsed_reg;
    logic [30:0]  t_reg;
    logic         last_reg;
    logic         final_reg;
    logic [63:0]  prod_reg;
    logic [31:0]  div_rem_reg;
    logic [48:0]  div_quo_reg;
    logic [31:0]  div_den_reg;
    logic [5:0]   div_cnt_reg;

    coord_t       in_axis [AXES];
    logic         in_xfer;
    logic         out_xfer;
    logic         push_ok;
    logic [30:0]  ts_nz;
    logic [30:0]  sp_nz;
    logic [31:0]  tick_t;
    logic         tick_over;
    logic         tick_last;
    logic         first_last;
    logic [32:0]  mag;
    logic [32:0]  div_sh;
    logic         div_ge;
    logic [31:0]  div_rem_step;
    logic [48:0]  div_quo_step;
    logic         div_last;
    logic [30:0]  iv_sat;
    logic [30:0]  iv_val;
    logic         q_big;
    coord_t       slope_val;
    logic [31:0]  slope_abs;
    logic [47:0]  mag48;
    logic [32:0]  clamp;
    logic signed [33:0] prod_s;
    logic signed [33:0] sum_s;
    coord_t       sum_sat;

    // Gather the axis fields into one array.
    assign in_axis[0] = lin_a;
    assign in_axis[1] = lin_b;
    assign in_axis[2] = lin_c;
    assign in_axis[3] = ang_a;
    assign in_axis[4] = ang_b;
    assign in_axis[5] = ang_c;

    // Handshakes.
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign out_xfer  = out_valid_reg && !out_stall;
    assign push_ok   = !out_valid_reg || !out_stall;
    assign cfg_ready = 1'b1;

    // Zero speed and zero time step count as one.
    assign ts_nz = (tstep_reg == '0) ? 31'd1 : tstep_reg;
    assign sp_nz = (speed_reg == '0) ? 31'd1 : speed_reg;

    // Tick timing: next time, past the end, and last point of the move.
    assign tick_t     = {1'b0, elapsed_reg} + {1'b0, ts_nz};
    assign tick_over  = tick_t > {1'b0, interval_reg};
    assign tick_last  = ({1'b0, tick_t} + {2'b00, ts_nz}) > {2'b00, interval_reg};
    assign first_last = ts_nz > interval_reg;

    // Magnitude of the selected axis difference.
    assign mag = diff_reg[idx_reg][32] ? 33'(-diff_reg[idx_reg]) : 33'(diff_reg[idx_reg]);

    // One restoring division step.
    assign div_sh       = {div_rem_reg, div_quo_reg[48]};
    assign div_ge       = div_sh >= {1'b0, div_den_reg};
    assign div_rem_step = div_ge ? 32'(div_sh - {1'b0, div_den_reg}) : div_sh[31:0];
    assign div_quo_step = {div_quo_reg[47:0], div_ge};
    assign div_last     = (div_cnt_reg == 6'(DIV_STEPS - 1));

    // Interval from the final quotient: saturate, then replace a zero with MIN_INTERVAL.
    assign iv_sat = (|div_quo_step[48:31]) ? 31'h7FFFFFFF : div_quo_step[30:0];
    assign iv_val = (iv_sat == '0) ? MIN_INTERVAL : iv_sat;

    // Signed, saturated slope from the final quotient.
    assign q_big = |div_quo_step[48:31];
    always_comb
    begin
        if (diff_reg[idx_reg][32])
        begin
            slope_val = q_big ? 32'sh80000000 : coord_t'(-div_quo_step[31:0]);
        end
        else
        begin
            slope_val = q_big ? 32'sh7FFFFFFF : coord_t'(div_quo_step[31:0]);
        end
    end

    // Point sum: clamp the scaled product, apply the sign, saturate the sum.
    assign slope_abs = slope_reg[idx_reg][31] ? 32'(-slope_reg[idx_reg])
                                              : 32'(slope_reg[idx_reg]);
    assign mag48  = prod_reg[63:16];
    assign clamp  = ((|mag48[47:32]) || (mag48[31:0] > 32'h80000000)) ? 33'h080000000
                                                                        : {1'b0, mag48[31:0]};
    assign prod_s = slope_reg[idx_reg][31] ? -$signed({1'b0, clamp}) : $signed({1'b0, clamp});
    assign sum_s  = 34'(start_reg[idx_reg]) + prod_s;
    always_comb
    begin
        if (sum_s > 34'sd2147483647)
        begin
            sum_sat = 32'sh7FFFFFFF;
        end
        else if (sum_s < -34'sd2147483648)
        begin
            sum_sat = 32'sh80000000;
        end
        else
        begin
            sum_sat = coord_t'(sum_s[31:0]);
        end
    end

    // Control state: sequencer, index, mode, output valid, pose and registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            moving_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            speed_reg     <= 31'd65536;
            tstep_reg     <= 31'd655;
            for (int i = 0; i < AXES; i++)
            begin
                cur_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_SPEED:     speed_reg <= cfg_data;
                    REG_TIME_STEP: tstep_reg <= cfg_data;
                    default:       ;
                endcase
            end
            // A transfer empties the output unless the push step refills it.
            if (out_xfer && !((state_reg == ST_PUSH) && push_ok))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_xfer)
                    begin
                        case (kind)
                            KIND_LOAD:
                            begin
                                for (int i = 0; i < AXES; i++)
                                begin
                                    cur_reg[i] <= in_axis[i];
                                end
                            end
                            KIND_TARGET:
                            begin
                                idx_reg   <= '0;
                                state_reg <= ST_MAG;
                            end
                            KIND_TICK:
                            begin
                                if (moving_reg)
                                begin
                                    if (tick_over)
                                    begin
                                        moving_reg <= 1'b0;
                                    end
                                    else
                                    begin
                                        moving_reg <= !tick_last;
                                        idx_reg    <= '0;
                                        state_reg  <= ST_MUL;
                                    end
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_MAG:
                begin
                    if (idx_reg == 3'(AXES))
                    begin
                        state_reg <= ST_IV_DIV;
                    end
                    else if (idx_reg < 3'(LINEAR_AXES))
                    begin
                        idx_reg <= idx_reg + 3'd1;
                    end
                    else
                    begin
                        state_reg <= ST_ANG_DIV;
                    end
                end
                ST_ANG_DIV:
                begin
                    if (div_last)
                    begin
                        idx_reg   <= idx_reg + 3'd1;
                        state_reg <= ST_MAG;
                    end
                end
                ST_IV_DIV:
                begin
                    if (div_last)
                    begin
                        idx_reg   <= '0;
                        state_reg <= ST_SLOPE_START;
                    end
                end
                ST_SLOPE_START:
                begin
                    state_reg <= ST_SLOPE_DIV;
                end
                ST_SLOPE_DIV:
                begin
                    if (div_last)
                    begin
                        if (idx_reg == 3'(AXES - 1))
                        begin
                            moving_reg <= !first_last;
                            idx_reg    <= '0;
                            state_reg  <= ST_MUL;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + 3'd1;
                            state_reg <= ST_SLOPE_START;
                        end
                    end
                end
                ST_MUL:
                begin
                    state_reg <= ST_ACC;
                end
                ST_ACC:
                begin
                    if (idx_reg == 3'(AXES - 1))
                    begin
                        state_reg <= ST_PUSH;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 3'd1;
                        state_reg <= ST_MUL;
                    end
                end
                ST_PUSH:
                begin
                    if (push_ok)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Datapath: differences, divider, slopes, products and points.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer && (kind == KIND_TARGET))
                begin
                    for (int i = 0; i < AXES; i++)
                    begin
                        diff_reg[i]  <= 33'(in_axis[i]) - 33'(cur_reg[i]);
                        start_reg[i] <= cur_reg[i];
                    end
                    max_reg <= '0;
                end
                if (in_xfer && (kind == KIND_TICK) && moving_reg && !tick_over)
                begin
                    elapsed_reg <= tick_t[30:0];
                    t_reg       <= tick_t[30:0];
                    last_reg    <= tick_last;
                end
            end
            ST_MAG:
            begin
                div_rem_reg <= '0;
                div_cnt_reg <= '0;
                if (idx_reg == 3'(AXES))
                begin
                    div_quo_reg <= {max_reg, 16'h0000};
                    div_den_reg <= {1'b0, sp_nz};
                end
                else if (idx_reg < 3'(LINEAR_AXES))
                begin
                    if (mag > max_reg)
                    begin
                        max_reg <= mag;
                    end
                end
                else
                begin
                    div_quo_reg <= {mag, 16'h0000};
                    div_den_reg <= PI_Q16;
                end
            end
            ST_ANG_DIV, ST_IV_DIV, ST_SLOPE_DIV:
            begin
                div_rem_reg <= div_rem_step;
                div_quo_reg <= div_quo_step;
                div_cnt_reg <= div_cnt_reg + 6'd1;
                if (div_last && (state_reg == ST_ANG_DIV) && (div_quo_step[32:0] > max_reg))
                begin
                    max_reg <= div_quo_step[32:0];
                end
                if (div_last && (state_reg == ST_IV_DIV))
                begin
                    interval_reg <= iv_val;
                end
                if (div_last && (state_reg == ST_SLOPE_DIV))
                begin
                    slope_reg[idx_reg] <= slope_val;
                    if (idx_reg == 3'(AXES - 1))
                    begin
                        elapsed_reg <= '0;
                        t_reg       <= '0;
                        last_reg    <= first_last;
                    end
                end
            end
            ST_SLOPE_START:
            begin
                div_rem_reg <= '0;
                div_cnt_reg <= '0;
                div_quo_reg <= {mag, 16'h0000};
                div_den_reg <= {1'b0, interval_reg};
            end
            ST_MUL:
            begin
                prod_reg <= slope_abs * {1'b0, t_reg};
            end
            ST_ACC:
            begin
                work_reg[idx_reg] <= sum_sat;
            end
            ST_PUSH:
            begin
                if (push_ok)
                begin
                    for (int i = 0; i < AXES; i++)
                    begin
                        pt_reg[i] <= work_reg[i];
                    end
                    final_reg <= last_reg;
                end
            end
            default: ;
        endcase
    end

    // Output ports.
    assign out_valid   = out_valid_reg;
    assign pt_lin_a    = pt_reg[0];
    assign pt_lin_b    = pt_reg[1];
    assign pt_lin_c    = pt_reg[2];
    assign pt_ang_a    = pt_reg[3];
    assign pt_ang_b    = pt_reg[4];
    assign pt_ang_c    = pt_reg[5];
    assign final_point = final_reg;

    // A running move always has a nonzero interval.
    a_moving_interval: assert property (@(posedge clk) disable iff (!rst_n)
        moving_reg |-> (interval_reg != '0))
        else $error("moving with zero interval");

    // The divider never runs on a zero divisor.
    a_div_den: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_ANG_DIV) || (state_reg == ST_IV_DIV) || (state_reg == ST_SLOPE_DIV))
        |-> (div_den_reg != '0))
        else $error("divide by zero");

    // A target transfer starts the planning sequence.
    a_target_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && (kind == KIND_TARGET)) |=> (state_reg == ST_MAG))
        else $error("target did not start planning");

    // A new point appears only from the push step.
    a_push_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_PUSH))
        else $error("output valid raised outside push");

endmodule
